// ===== sv/ilfl_pkg.sv =====
// ----------------------------------------------------------------------------
// ilfl_pkg
// Shared constants, types and helpers of the IPv4 LPM/ECMP lookup core.
// ----------------------------------------------------------------------------
package ilfl_pkg;

    localparam int PRIMARY_DEPTH   = 256;
    localparam int ALTERNATE_DEPTH = 256;
    localparam int MAX_ECMP        = 16;

    localparam int PRI_AW = (PRIMARY_DEPTH > 1) ? $clog2(PRIMARY_DEPTH) : 1;
    localparam int ALT_AW = (ALTERNATE_DEPTH > 1) ? $clog2(ALTERNATE_DEPTH) : 1;
    localparam int IDX_W  = (PRI_AW > ALT_AW) ? PRI_AW : ALT_AW;
    localparam int PCNT_W = $clog2(PRIMARY_DEPTH + 1);
    localparam int ACNT_W = $clog2(ALTERNATE_DEPTH + 1);
    localparam int CNT_W  = (PCNT_W > ACNT_W) ? PCNT_W : ACNT_W;
    localparam int EQ_AW  = (MAX_ECMP > 1) ? $clog2(MAX_ECMP) : 1;
    localparam int EQN_W  = $clog2(MAX_ECMP + 1);

    // route word: net(32) len(6) hop(32) port(8) local(1)
    localparam int ROUTE_W = 79;
    // class word: pref(8) origin(4) rank(8) cost(32) inst(16)
    localparam int CLASS_W = 68;

    localparam logic [2:0] OP_CLEAR      = 3'd0;
    localparam logic [2:0] OP_APPEND_PRI = 3'd1;
    localparam logic [2:0] OP_APPEND_ALT = 3'd2;
    localparam logic [2:0] OP_LOOKUP_PRI = 3'd3;
    localparam logic [2:0] OP_LOOKUP_ALT = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOROUTE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [31:0] net;
        logic [5:0]  len;
        logic [31:0] hop;
        logic [7:0]  port;
        logic        local_flag;
    } t_route;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic [31:0] hop_address;
        logic [7:0]  out_port;
        logic        is_local;
        logic [7:0]  admin_pref;
        logic [31:0] route_cost;
        logic [3:0]  origin_kind;
        logic [2:0]  ospf_kind;
        logic [15:0] instance_id;
        logic [63:0] flow_key;
    } t_item;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input word
        logic scan_start; // reset scan state
        logic scan_step;  // evaluate entry returned by RAM
        logic rd_issue;   // issue table read at scan index
        logic mod_start;
        logic mod_step;
        logic sel_issue;  // read route at the chosen list entry
        logic sel_take;
        logic fin;        // build result word
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] opcode;
        logic       scan_last; // scan index reached table count
        logic       mod_done;
        logic       have;      // scan found a matching route
    } t_stat;

    function automatic logic [31:0] mask_of(input logic [5:0] len);
        logic [5:0] l;
        l = (len > 6'd32) ? 6'd32 : len;
        if (l == 6'd0) return 32'd0;
        return 32'hFFFF_FFFF << (6'd32 - l);
    endfunction

    function automatic logic [7:0] rank_of(input logic [2:0] k);
        case (k)
            3'd0: return 8'd0;
            3'd1: return 8'd1;
            3'd2: return 8'd2;
            3'd3, 3'd5: return 8'd3;
            3'd4, 3'd6: return 8'd4;
            default: return 8'hFF;
        endcase
    endfunction

endpackage

// ===== sv/ilfl_ram.sv =====
// ----------------------------------------------------------------------------
// ilfl_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ilfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== sv/ilfl_divmod.sv =====
// ----------------------------------------------------------------------------
// ilfl_divmod
// Restoring remainder of a 64-bit key by a small count, one bit per cycle while i_step is high.
// ----------------------------------------------------------------------------
module ilfl_divmod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_step,
    input  logic [63:0]                i_key,
    input  logic [ilfl_pkg::EQN_W-1:0] i_div,
    output logic [ilfl_pkg::EQN_W-1:0] o_rem,
    output logic                       o_done
);
    import ilfl_pkg::*;

    logic [63:0]      r_key;
    logic [EQN_W:0]   r_rem;
    logic [6:0]       r_cnt;
    logic [EQN_W:0]   n_trial;

    assign n_trial = {r_rem[EQN_W-1:0], r_key[63]};
    assign o_rem   = r_rem[EQN_W-1:0];
    assign o_done  = (r_cnt == 7'd64);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 7'd0;
        end else if (i_start) begin
            r_key <= i_key;
            r_rem <= '0;
            r_cnt <= 7'd0;
        end else if (i_step && !o_done) begin
            r_key <= {r_key[62:0], 1'b0};
            r_rem <= (n_trial >= {1'b0, i_div}) ? n_trial - {1'b0, i_div} : n_trial;
            r_cnt <= r_cnt + 7'd1;
        end
    end
endmodule

// ===== sv/ilfl_datapath.sv =====
// ----------------------------------------------------------------------------
// ilfl_datapath
// Tables, counts, scan state, ECMP list and result register.
// ----------------------------------------------------------------------------
module ilfl_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ilfl_pkg::t_item      i_item,
    input  ilfl_pkg::t_cmd       i_cmd,
    output ilfl_pkg::t_stat      o_stat,
    output logic [1:0]           o_status,
    output ilfl_pkg::t_route     o_sel
);
    import ilfl_pkg::*;

    t_item              r_item;
    logic [PCNT_W-1:0]  r_pcnt;
    logic [ACNT_W-1:0]  r_acnt;
    logic [CNT_W-1:0]   r_idx;      // next index to read
    logic [CNT_W-1:0]   r_eidx;     // index of entry now on RAM output
    logic               r_have;
    t_route             r_best;
    logic [CLASS_W-1:0] r_bcls;
    logic [EQN_W-1:0]   r_n;
    logic [1:0]         r_status;
    t_route             r_sel;

    logic               is_pri;
    logic [CNT_W-1:0]   count;
    t_route             new_rt;
    logic [CLASS_W-1:0] new_cls;
    logic [ROUTE_W-1:0] p_rd, a_rd;
    logic [CLASS_W-1:0] c_rd;
    logic [IDX_W-1:0]   eq_rd;
    t_route             c_rt;
    logic               p_we, a_we, eq_we;
    logic [PRI_AW-1:0]  p_ra;
    logic [ALT_AW-1:0]  a_ra;
    logic [EQ_AW-1:0]   eq_wa, eq_ra;
    logic [IDX_W-1:0]   eq_wd;
    logic [EQN_W-1:0]   rem;
    logic               match, longer, equal;

    assign is_pri = (r_item.opcode == OP_LOOKUP_PRI);
    assign count  = is_pri ? CNT_W'(r_pcnt) : CNT_W'(r_acnt);

    always_comb begin
        logic [5:0] l;
        l = (r_item.prefix_len > 6'd32) ? 6'd32 : r_item.prefix_len;
        new_rt.net        = r_item.address & mask_of(l);
        new_rt.len        = l;
        new_rt.hop        = r_item.hop_address;
        new_rt.port       = r_item.out_port;
        new_rt.local_flag = r_item.is_local;
        new_cls = {r_item.admin_pref, r_item.origin_kind, rank_of(r_item.ospf_kind),
                   r_item.route_cost, r_item.instance_id};
    end

    assign p_we = i_cmd.fin && r_item.opcode == OP_APPEND_PRI
                  && r_pcnt < PCNT_W'(PRIMARY_DEPTH);
    assign a_we = i_cmd.fin && r_item.opcode == OP_APPEND_ALT
                  && r_acnt < ACNT_W'(ALTERNATE_DEPTH);

    always_comb begin
        p_ra = r_idx[PRI_AW-1:0];
        a_ra = r_idx[ALT_AW-1:0];
        if (i_cmd.sel_issue) begin
            p_ra = eq_rd[PRI_AW-1:0];
            a_ra = eq_rd[ALT_AW-1:0];
        end
    end

    ilfl_ram #(.WIDTH(ROUTE_W), .DEPTH(PRIMARY_DEPTH)) u_pri (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(r_pcnt[PRI_AW-1:0]),
        .i_wdata(new_rt), .i_raddr(p_ra), .o_rdata(p_rd));
    ilfl_ram #(.WIDTH(CLASS_W), .DEPTH(PRIMARY_DEPTH)) u_cls (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(r_pcnt[PRI_AW-1:0]),
        .i_wdata(new_cls), .i_raddr(p_ra), .o_rdata(c_rd));
    ilfl_ram #(.WIDTH(ROUTE_W), .DEPTH(ALTERNATE_DEPTH)) u_alt (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(r_acnt[ALT_AW-1:0]),
        .i_wdata(new_rt), .i_raddr(a_ra), .o_rdata(a_rd));

    assign c_rt   = is_pri ? t_route'(p_rd) : t_route'(a_rd);
    assign match  = (r_item.address & mask_of(c_rt.len)) == c_rt.net;
    assign longer = !r_have || c_rt.len > r_best.len;
    assign equal  = c_rt.len == r_best.len && c_rt.net == r_best.net
                    && (!is_pri || c_rd == r_bcls) && r_n < EQN_W'(MAX_ECMP);

    assign eq_we = i_cmd.scan_step && match && (longer || equal);
    assign eq_wa = longer ? '0 : r_n[EQ_AW-1:0];
    assign eq_wd = IDX_W'(r_eidx);
    assign eq_ra = rem[EQ_AW-1:0];

    // equal list: written during scan, read once with the ECMP pick
    ilfl_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ECMP)) u_eq (
        .i_clk(i_clk), .i_we(eq_we), .i_waddr(eq_wa), .i_wdata(eq_wd),
        .i_raddr(eq_ra), .o_rdata(eq_rd));

    ilfl_divmod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.mod_start),
        .i_step(i_cmd.mod_step), .i_key(r_item.flow_key), .i_div(r_n),
        .o_rem(rem), .o_done(o_stat.mod_done));

    assign o_stat.opcode    = r_item.opcode;
    assign o_stat.scan_last = (r_idx == count);
    assign o_stat.have      = r_have;
    assign o_status = r_status;
    assign o_sel    = r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= '0;
            r_acnt <= '0;
            r_have <= 1'b0;
            r_n    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_item <= i_item;
            end
            if (i_cmd.scan_start) begin
                r_idx  <= '0;
                r_have <= 1'b0;
                r_n    <= '0;
            end
            if (i_cmd.rd_issue) begin
                r_eidx <= r_idx;
                r_idx  <= r_idx + CNT_W'(1);
            end
            if (eq_we) begin
                if (longer) begin
                    r_have <= 1'b1;
                    r_best <= c_rt;
                    r_bcls <= c_rd;
                    r_n    <= EQN_W'(1);
                end else begin
                    r_n <= r_n + EQN_W'(1);
                end
            end
            if (i_cmd.fin) begin
                case (r_item.opcode)
                    OP_CLEAR: begin
                        r_pcnt   <= '0;
                        r_acnt   <= '0;
                        r_sel    <= '0;
                        r_status <= ST_OK;
                    end
                    OP_APPEND_PRI: begin
                        r_sel <= '0;
                        if (p_we) begin
                            r_pcnt   <= r_pcnt + PCNT_W'(1);
                            r_status <= ST_OK;
                        end else begin
                            r_status <= ST_FULL;
                        end
                    end
                    OP_APPEND_ALT: begin
                        r_sel <= '0;
                        if (a_we) begin
                            r_acnt   <= r_acnt + ACNT_W'(1);
                            r_status <= ST_OK;
                        end else begin
                            r_status <= ST_FULL;
                        end
                    end
                    OP_LOOKUP_PRI, OP_LOOKUP_ALT: begin
                        // chosen route sits on the RAM output now
                        if (i_cmd.sel_take) begin
                            r_sel    <= c_rt;
                            r_status <= ST_OK;
                        end else begin
                            r_status <= ST_NOROUTE;
                            r_sel    <= '0;
                        end
                    end
                    default: begin
                        r_sel    <= '0;
                        r_status <= ST_OK;
                    end
                endcase
            end
        end
    end
endmodule

// ===== sv/ilfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilfl_ctrl
// Sequencer: accept, scan, modulo, pick, deliver.
// ----------------------------------------------------------------------------
module ilfl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ilfl_pkg::t_stat i_stat,
    output ilfl_pkg::t_cmd  o_cmd
);
    import ilfl_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DEC  = 8'b0000_0010,
        S_SCAN = 8'b0000_0100,
        S_MOD  = 8'b0000_1000,
        S_SEL1 = 8'b0001_0000,
        S_SEL2 = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_pend; // a read was issued last cycle, its data is on the RAM port
    logic   n_pend;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_pend  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.opcode == OP_LOOKUP_PRI || i_stat.opcode == OP_LOOKUP_ALT) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = r_pend;
                if (!i_stat.scan_last) begin
                    o_cmd.rd_issue = 1'b1;
                    n_pend         = 1'b1;
                end else if (!r_pend) begin
                    o_cmd.mod_start = 1'b1;
                    n_state         = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_done) begin
                    n_state = i_stat.have ? S_SEL1 : S_FIN;
                end
            end
            S_SEL1: n_state = S_SEL2; // list read in flight
            S_SEL2: begin
                o_cmd.sel_issue = 1'b1;
                n_state         = S_FIN;
            end
            S_FIN: begin
                o_cmd.sel_take = i_stat.have;
                o_cmd.fin      = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end
endmodule

// ===== sv/ipv4_lpm_ecmp_fib_lookup_core.sv =====
// ----------------------------------------------------------------------------
// ipv4_lpm_ecmp_fib_lookup_core
// IPv4 longest-prefix-match lookup with ECMP selection over two route tables.
// ----------------------------------------------------------------------------
// Usage: one command word enters on the s_axis group, one result word leaves
// on the m_axis group for every command. Commands clear both tables, append a
// route to the primary or alternate table, or look up a destination.
// Appends, clears and unused opcodes go from decode straight to the result
// stage. A lookup reads the chosen table through its RAM port one entry per
// cycle, then forms the bit-serial remainder of the flow key by the number
// of equal-cost matches, reads the list entry so picked and then its route;
// with no match it skips both reads and reports no route. One command is in
// flight at a time; s_axis_tready is high only while idle, the cycle after
// the result word is taken.
// Reset empties both tables (counts to zero); no clearing pass is needed.
// A stalled receiver holds the result word and the block takes no new
// command until it is read.
// ----------------------------------------------------------------------------
module ipv4_lpm_ecmp_fib_lookup_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode, address, prefix_len, hop_address, out_port, is_local,
    // admin_pref, route_cost, origin_kind, ospf_kind, instance_id, flow_key
    input  logic [215:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, sel_network, sel_prefix_len, sel_next_hop, sel_port, sel_local
    output logic [87:0]  m_axis_tdata
);
    import ilfl_pkg::*;

    t_item  item;
    t_cmd   cmd;
    t_stat  stat;
    t_route sel;
    logic [1:0] status;

    assign item.opcode      = s_axis_tdata[2:0];
    assign item.address     = s_axis_tdata[34:3];
    assign item.prefix_len  = s_axis_tdata[40:35];
    assign item.hop_address = s_axis_tdata[72:41];
    assign item.out_port    = s_axis_tdata[80:73];
    assign item.is_local    = s_axis_tdata[81];
    assign item.admin_pref  = s_axis_tdata[89:82];
    assign item.route_cost  = s_axis_tdata[121:90];
    assign item.origin_kind = s_axis_tdata[125:122];
    assign item.ospf_kind   = s_axis_tdata[128:126];
    assign item.instance_id = s_axis_tdata[144:129];
    assign item.flow_key    = s_axis_tdata[208:145];

    ilfl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(stat), .o_cmd(cmd));

    ilfl_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item), .i_cmd(cmd),
        .o_stat(stat), .o_status(status), .o_sel(sel));

    assign m_axis_tdata = {7'd0, sel.local_flag, sel.port, sel.hop, sel.len,
                           sel.net, status};
endmodule
